FILE: hw/rtl/flight_phase_detector_assert.svh
// Assertion macros for the flight phase detector.
// FPD_ASSERT checks a property on every rising edge of aclk outside reset.
// FPD_ASSERT_NEVER checks that an expression is never true outside reset.
`ifndef FLIGHT_PHASE_DETECTOR_ASSERT_SVH
`define FLIGHT_PHASE_DETECTOR_ASSERT_SVH

`ifndef SYNTHESIS

`define FPD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("flight_phase_detector: property failed");

`define FPD_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error("flight_phase_detector: forbidden condition seen");

`else

`define FPD_ASSERT(lbl, prop)

`define FPD_ASSERT_NEVER(lbl, expr)

`endif

`endif

FILE: hw/rtl/fpd_pkg.sv
package fpd_pkg;

    localparam int WINDOW_DEPTH = 50;
    localparam int WIN_ADDR_W   = $clog2(WINDOW_DEPTH);
    localparam int SAMPLE_W     = 24;
    localparam int CFG_INDEX_W  = 8;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [1:0]                 phase_t;

    localparam sample_t SAMPLE_MAX = 24'sh7FFFFF;

    localparam phase_t PH_WAITING        = 2'd0;
    localparam phase_t PH_ASCENT         = 2'd1;
    localparam phase_t PH_DESCENT        = 2'd2;
    localparam phase_t PH_MAIN_PARACHUTE = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_ASCENT_THRESHOLD    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PARACHUTE_THRESHOLD = 8'd1;

    localparam sample_t ASCENT_THRESHOLD_RST    = 24'sd2304;
    localparam sample_t PARACHUTE_THRESHOLD_RST = 24'sd3072;

    typedef struct packed {
        logic                  rd_en;
        logic [WIN_ADDR_W-1:0] rd_addr;
        logic                  wr_en;
        logic [WIN_ADDR_W-1:0] wr_addr;
        sample_t               wr_data;
    } win_req_t;

endpackage

FILE: hw/rtl/fpd_window.sv
module fpd_window (
    input  logic              aclk,
    input  logic              aresetn,
    input  fpd_pkg::win_req_t win_req,
    output fpd_pkg::sample_t  rd_data
);

    fpd_pkg::sample_t                      win_mem [0:fpd_pkg::WINDOW_DEPTH-1];
    logic [fpd_pkg::WINDOW_DEPTH-1:0]      written_reg;
    logic [fpd_pkg::WINDOW_DEPTH-1:0]      written_next;
    fpd_pkg::sample_t                      rd_data_reg;
    logic                                  rd_hit_reg;

    always_comb begin
        written_next = written_reg;
        if (win_req.wr_en) begin
            written_next[win_req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else begin
            written_reg <= written_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (win_req.wr_en) begin
            win_mem[win_req.wr_addr] <= win_req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (win_req.rd_en) begin
            rd_data_reg <= win_mem[win_req.rd_addr];
            rd_hit_reg  <= written_reg[win_req.rd_addr];
        end
    end

    // unwritten entries read as zero
    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

FILE: hw/rtl/fpd_core.sv
module fpd_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  fpd_pkg::sample_t   in_sample,
    output logic               out_valid,
    input  logic               out_ready,
    output fpd_pkg::phase_t    out_phase,
    output logic               out_changed,
    input  fpd_pkg::sample_t   ascent_threshold,
    input  fpd_pkg::sample_t   parachute_threshold,
    output fpd_pkg::win_req_t  win_req,
    input  fpd_pkg::sample_t   win_rd_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    localparam logic [fpd_pkg::WIN_ADDR_W-1:0] LAST_ADDR =
        fpd_pkg::WIN_ADDR_W'(fpd_pkg::WINDOW_DEPTH - 1);

    logic [1:0]                       state_reg,      state_next;
    fpd_pkg::sample_t                 sample_reg,     sample_next;
    fpd_pkg::sample_t                 min_reg,        min_next;
    logic [fpd_pkg::WIN_ADDR_W-1:0]   scan_idx_reg,   scan_idx_next;
    logic                             rd_pend_reg,    rd_pend_next;
    logic [fpd_pkg::WIN_ADDR_W-1:0]   wr_pos_reg,     wr_pos_next;
    fpd_pkg::phase_t                  phase_reg,      phase_next;
    logic                             out_valid_reg,  out_valid_next;
    fpd_pkg::phase_t                  out_phase_reg,  out_phase_next;
    logic                             out_changed_reg, out_changed_next;

    fpd_pkg::sample_t cmp_a;
    fpd_pkg::sample_t cmp_b;
    logic             cmp_lt;
    logic             out_free;
    logic             step;

    // shared signed comparator
    always_comb begin
        cmp_a = win_rd_data;
        cmp_b = min_reg;
        if (state_reg == ST_DECIDE) begin
            unique case (phase_reg)
                fpd_pkg::PH_WAITING: begin
                    cmp_a = ascent_threshold;
                    cmp_b = sample_reg;
                end
                fpd_pkg::PH_ASCENT: begin
                    cmp_a = sample_reg;
                    cmp_b = min_reg;
                end
                fpd_pkg::PH_DESCENT: begin
                    cmp_a = sample_reg;
                    cmp_b = parachute_threshold;
                end
                default: begin
                    cmp_a = sample_reg;
                    cmp_b = sample_reg;
                end
            endcase
        end
    end

    assign cmp_lt   = cmp_a < cmp_b;
    assign out_free = !out_valid_reg || out_ready;
    assign step     = cmp_lt && (phase_reg != fpd_pkg::PH_MAIN_PARACHUTE);

    always_comb begin
        state_next       = state_reg;
        sample_next      = sample_reg;
        min_next         = min_reg;
        scan_idx_next    = scan_idx_reg;
        rd_pend_next     = 1'b0;
        wr_pos_next      = wr_pos_reg;
        phase_next       = phase_reg;
        out_valid_next   = out_valid_reg;
        out_phase_next   = out_phase_reg;
        out_changed_next = out_changed_reg;

        win_req         = '0;
        win_req.rd_addr = scan_idx_reg;
        win_req.wr_addr = wr_pos_reg;
        win_req.wr_data = sample_reg;

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        if (rd_pend_reg && cmp_lt) begin
            min_next = win_rd_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    sample_next   = in_sample;
                    min_next      = fpd_pkg::SAMPLE_MAX;
                    scan_idx_next = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                win_req.rd_en = 1'b1;
                rd_pend_next  = 1'b1;
                if (scan_idx_reg == LAST_ADDR) begin
                    state_next = ST_DRAIN;
                end else begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                // hold until the result register is free
                if (out_free) begin
                    win_req.wr_en    = 1'b1;
                    wr_pos_next      = (wr_pos_reg == LAST_ADDR) ? '0 : wr_pos_reg + 1'b1;
                    phase_next       = step ? phase_reg + 1'b1 : phase_reg;
                    out_valid_next   = 1'b1;
                    out_phase_next   = step ? phase_reg + 1'b1 : phase_reg;
                    out_changed_next = step;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            scan_idx_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            wr_pos_reg    <= '0;
            phase_reg     <= fpd_pkg::PH_WAITING;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            rd_pend_reg   <= rd_pend_next;
            wr_pos_reg    <= wr_pos_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg      <= sample_next;
        min_reg         <= min_next;
        out_phase_reg   <= out_phase_next;
        out_changed_reg <= out_changed_next;
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign out_phase   = out_phase_reg;
    assign out_changed = out_changed_reg;

endmodule

FILE: hw/rtl/flight_phase_detector.sv
// Flight phase detector: takes one signed Q15.8 altitude request per item and
// returns the flight phase (waiting, ascent, descent, main parachute) after it,
// with a flag set when that request moved the phase on. A new request is not
// taken until the previous one has been decided and written back. One window
// entry is read from the window memory (separate read and write ports) and
// passed through the one shared comparator per cycle, a drain step then takes
// in the last read, then the comparator settles the phase decision and the
// sample is written back. A finished result waits in an output register while
// the next request is being worked on; the decision step holds only if that
// register is still full. The threshold registers may be written at any time
// the block is idle and the window needs no clearing after reset.
`include "flight_phase_detector_assert.svh"

module flight_phase_detector (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,   // [23:0] altitude_sample
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [1:0] phase, [2] phase_changed
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fpd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fpd_pkg::SAMPLE_W-1:0]        cfg_data
);

    fpd_pkg::sample_t  ascent_thr_reg, ascent_thr_next;
    fpd_pkg::sample_t  para_thr_reg,   para_thr_next;
    fpd_pkg::win_req_t win_req;
    fpd_pkg::sample_t  win_rd_data;
    fpd_pkg::phase_t   out_phase;
    logic              out_changed;

    assign cfg_ready = 1'b1;

    always_comb begin
        ascent_thr_next = ascent_thr_reg;
        para_thr_next   = para_thr_reg;
        if (cfg_valid) begin
            priority if (cfg_index == fpd_pkg::REG_ASCENT_THRESHOLD) begin
                ascent_thr_next = cfg_data;
            end else if (cfg_index == fpd_pkg::REG_PARACHUTE_THRESHOLD) begin
                para_thr_next = cfg_data;
            end else begin
                // drop writes to unknown indexes
                ascent_thr_next = ascent_thr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ascent_thr_reg <= fpd_pkg::ASCENT_THRESHOLD_RST;
            para_thr_reg   <= fpd_pkg::PARACHUTE_THRESHOLD_RST;
        end else begin
            ascent_thr_reg <= ascent_thr_next;
            para_thr_reg   <= para_thr_next;
        end
    end

    fpd_core u_core (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .in_valid            (s_tvalid),
        .in_ready            (s_tready),
        .in_sample           (s_tdata),
        .out_valid           (m_tvalid),
        .out_ready           (m_tready),
        .out_phase           (out_phase),
        .out_changed         (out_changed),
        .ascent_threshold    (ascent_thr_reg),
        .parachute_threshold (para_thr_reg),
        .win_req             (win_req),
        .win_rd_data         (win_rd_data)
    );

    fpd_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .win_req (win_req),
        .rd_data (win_rd_data)
    );

    assign m_tdata = {5'b0, out_changed, out_phase};

    `FPD_ASSERT(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready)
    `FPD_ASSERT(a_result_after_write, win_req.wr_en |=> m_tvalid)
    `FPD_ASSERT_NEVER(a_no_read_during_write, win_req.rd_en && win_req.wr_en)
    `FPD_ASSERT(a_change_leaves_waiting,
        (m_tvalid && m_tdata[2]) |-> (m_tdata[1:0] != fpd_pkg::PH_WAITING))

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import fpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam sample_t SAMPLE_MIN = 24'sh800000;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TOP    = 8'hFF;

    typedef struct packed {
        phase_t phase;
        logic   moved;
    } phase_report_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [23:0]            s_tdata   = '0;   // [23:0] altitude_sample
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [7:0]             m_tdata;          // [1:0] phase, [2] phase_changed
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [SAMPLE_W-1:0]    cfg_data  = '0;

    flight_phase_detector u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    sample_t       alt_window [WINDOW_DEPTH];
    int            alt_wr_ptr = 0;
    phase_t        flight     = PH_WAITING;
    sample_t       ascent_thr = ASCENT_THRESHOLD_RST;
    sample_t       chute_thr  = PARACHUTE_THRESHOLD_RST;

    sample_t       altitudes_pending [$];
    phase_report_t reports_due [$];

    bit            jitter     = 1'b1;
    bit            in_fire    = 1'b0;
    bit            drained    = 1'b0;
    int            in_gap     = 0;
    int            out_gap    = 0;
    int            cfg_writes = 0;
    int            quiet      = 0;
    int            errors     = 0;

    function automatic sample_t window_lowest();
        sample_t lowest;
        lowest = alt_window[0];
        for (int i = 1; i < WINDOW_DEPTH; i++) begin
            if (alt_window[i] < lowest) lowest = alt_window[i];
        end
        return lowest;
    endfunction

    function automatic phase_report_t step_flight(sample_t alt);
        phase_report_t rep;
        sample_t       lowest;
        lowest    = window_lowest();
        rep.moved = 1'b0;
        case (flight)
            PH_WAITING: if (alt > ascent_thr) begin
                flight    = PH_ASCENT;
                rep.moved = 1'b1;
            end
            PH_ASCENT: if (alt < lowest) begin
                flight    = PH_DESCENT;
                rep.moved = 1'b1;
            end
            PH_DESCENT: if (alt < chute_thr) begin
                flight    = PH_MAIN_PARACHUTE;
                rep.moved = 1'b1;
            end
            default: ;
        endcase
        alt_window[alt_wr_ptr] = alt;
        alt_wr_ptr = (alt_wr_ptr + 1 == WINDOW_DEPTH) ? 0 : alt_wr_ptr + 1;
        rep.phase = flight;
        return rep;
    endfunction

    function automatic int stall_length();
        return int'($urandom_range(1, 6));
    endfunction

    function automatic sample_t pick_above(int lo);
        return sample_t'(lo + int'($urandom_range(int'(SAMPLE_MAX) - lo)));
    endfunction

    // hold each request until accepted, then idle or advance
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || in_fire) begin
                if (in_gap == 0 && jitter && $urandom_range(0, 7) == 0) in_gap = stall_length();
                if (in_gap > 0) begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end else if (altitudes_pending.size() != 0) begin
                    s_tdata  <= altitudes_pending.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (out_gap == 0 && jitter && $urandom_range(0, 7) == 0) out_gap = stall_length();
            if (out_gap > 0) begin
                out_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        phase_report_t want;
        if (aresetn) begin
            in_fire = s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                if (reports_due.size() == 0) begin
                    $display("%0t unexpected result: expected none, got %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = reports_due.pop_front();
                    if (m_tdata[1:0] !== want.phase) begin
                        $display("%0t phase: expected %0d, got %0d",
                                 $time, want.phase, m_tdata[1:0]);
                        errors++;
                    end
                    if (m_tdata[2] !== want.moved) begin
                        $display("%0t phase_changed: expected %0d, got %0d",
                                 $time, want.moved, m_tdata[2]);
                        errors++;
                    end
                    if (m_tdata[7:3] !== 5'd0) begin
                        $display("%0t tdata padding: expected 0, got %h", $time, m_tdata[7:3]);
                        errors++;
                    end
                end
            end
            if (in_fire) reports_due.push_back(step_flight(s_tdata));
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ASCENT_THRESHOLD:    ascent_thr = cfg_data;
                    REG_PARACHUTE_THRESHOLD: chute_thr  = cfg_data;
                    default: ;
                endcase
                cfg_writes++;
            end
            if (in_fire || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) quiet = 0;
            else quiet++;
            drained = altitudes_pending.size() == 0 && !s_tvalid && reports_due.size() == 0;
            if (quiet == WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic settle();
        do @(negedge aclk); while (!drained);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input sample_t val);
        int seen;
        seen = cfg_writes;
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge aclk); while (cfg_writes == seen);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int floor_v;
        int thr;
        for (int i = 0; i < WINDOW_DEPTH; i++) alt_window[i] = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // waiting: equal to the threshold stays put
        altitudes_pending.push_back(24'sd2304);
        altitudes_pending.push_back(24'sd2303);
        settle();
        write_reg(REG_UNUSED, sample_t'($urandom));
        write_reg(REG_TOP, sample_t'($urandom));
        write_reg(REG_ASCENT_THRESHOLD, SAMPLE_MAX);
        altitudes_pending.push_back(SAMPLE_MAX);
        settle();
        write_reg(REG_ASCENT_THRESHOLD, 24'sd5);
        altitudes_pending.push_back(24'sd5);
        altitudes_pending.push_back(24'sd6);
        // zeros left from reset still hold the minimum down
        altitudes_pending.push_back(24'sd0);
        altitudes_pending.push_back(24'sh555555);

        // climb: every batch stays at or above the previous floor
        floor_v = 0;
        repeat (10) begin
            settle();
            jitter = ($urandom_range(0, 3) != 0);
            altitudes_pending.push_back(window_lowest());
            repeat (50) begin
                altitudes_pending.push_back(($urandom_range(0, 15) == 0) ?
                                            sample_t'(floor_v) : pick_above(floor_v));
            end
            floor_v += $urandom_range(0, 600000);
        end
        settle();
        altitudes_pending.push_back(window_lowest() - 24'sd1);

        // descent: hold at or above the parachute threshold
        settle();
        jitter = 1'b1;
        write_reg(REG_PARACHUTE_THRESHOLD, SAMPLE_MIN);
        write_reg(REG_ASCENT_THRESHOLD, SAMPLE_MIN);
        repeat (100) begin
            altitudes_pending.push_back(($urandom_range(0, 19) == 0) ?
                                        SAMPLE_MIN : sample_t'($urandom));
        end
        repeat (6) begin
            settle();
            thr = int'(sample_t'($urandom));
            write_reg(REG_PARACHUTE_THRESHOLD, sample_t'(thr));
            jitter = ($urandom_range(0, 3) != 0);
            repeat (60) begin
                altitudes_pending.push_back(($urandom_range(0, 9) == 0) ?
                                            sample_t'(thr) : pick_above(thr));
            end
        end
        settle();
        write_reg(REG_PARACHUTE_THRESHOLD, SAMPLE_MAX);
        altitudes_pending.push_back(24'sd0);

        // main parachute is final: anything goes
        repeat (5) begin
            settle();
            write_reg(REG_ASCENT_THRESHOLD, sample_t'($urandom));
            write_reg(REG_PARACHUTE_THRESHOLD, sample_t'($urandom));
            write_reg(CFG_INDEX_W'($urandom_range(2, 255)), sample_t'($urandom));
            jitter = ($urandom_range(0, 3) != 0);
            repeat (70) altitudes_pending.push_back(sample_t'($urandom));
        end
        settle();
        jitter  = 1'b0;
        in_gap  = 0;
        out_gap = 0;
        repeat (200) altitudes_pending.push_back(sample_t'($urandom));
        settle();
        repeat (120) @(posedge aclk);
        errors += reports_due.size();
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/fpd_pkg.sv
hw/rtl/fpd_window.sv
hw/rtl/fpd_core.sv
hw/rtl/flight_phase_detector.sv
bench/tb.sv
